### rtl/lpht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Types, sizes and mix constants shared by the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_BITS = 16;
  localparam int SLOT_COUNT = 1 << TABLE_BITS;
  localparam int CNT_W      = TABLE_BITS + 1;

  localparam logic [TABLE_BITS-1:0] SLOT_MASK  = {TABLE_BITS{1'b1}};
  // count * 10 > slots * 9 is the same as count > floor(slots * 9 / 10)
  localparam logic [CNT_W-1:0]      LOAD_LIMIT = CNT_W'((SLOT_COUNT * 9) / 10);

  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] key;
    logic [63:0] value;
  } lpht_req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] found_value;
    logic [16:0] occupancy;
  } lpht_rsp_t;

  // one access of the slot store
  typedef struct packed {
    logic                  en;
    logic                  key_we;
    logic                  val_we;
    logic [TABLE_BITS-1:0] addr;
    logic [63:0]           wkey;
    logic [63:0]           wval;
  } store_req_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MIX1,
    HS_MIX2
  } hash_state_e;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HASH,
    CS_PROBE,
    CS_RESP
  } core_state_e;

  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage
`default_nettype wire

### rtl/lpht_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_hash
// Home slot mixer: two 64-bit constant multiplies built from one shared
// 32x32 multiplier, three partial products per multiply.
// ----------------------------------------------------------------------------
module lpht_hash
  import lpht_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [63:0]           key_i,
  output logic                       done_o,
  output logic [TABLE_BITS-1:0]      slot_o
);

  hash_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] mul_c;
  logic [31:0] op_a, op_b;
  logic [63:0] addend;
  logic [63:0] acc_sum;
  logic [63:0] mix_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  // low 64 bits of x * c: lo*lo, then lo*hi and hi*lo shifted up by 32
  always_comb begin
    mul_c = (state_q == HS_MIX1) ? MIX_C1 : MIX_C2;
    unique case (step_q)
      2'd0: begin
        op_a = x_q[31:0];
        op_b = mul_c[31:0];
      end
      2'd1: begin
        op_a = x_q[31:0];
        op_b = mul_c[63:32];
      end
      default: begin
        op_a = x_q[63:32];
        op_b = mul_c[31:0];
      end
    endcase
    prod_d  = op_a * op_b;
    addend  = (step_q == 2'd1) ? prod_q : {prod_q[31:0], 32'd0};
    acc_sum = acc_q + addend;
    mix_out = xor_shift(acc_sum);
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    x_d     = x_q;
    acc_d   = (step_q == 2'd0) ? 64'd0 : acc_sum;
    done_o  = 1'b0;
    slot_o  = mix_out[TABLE_BITS-1:0];
    unique case (state_q)
      HS_IDLE: begin
        step_d = 2'd0;
        if (start_i) begin
          x_d     = xor_shift(key_i);
          state_d = HS_MIX1;
        end
      end
      HS_MIX1: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          x_d     = mix_out;
          state_d = HS_MIX2;
        end
      end
      HS_MIX2: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          done_o  = 1'b1;
          state_d = HS_IDLE;
        end
      end
      default: begin
        state_d = HS_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/lpht_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_store
// Slot store: key and value memories on one shared address, registered read.
// ----------------------------------------------------------------------------
module lpht_store
  import lpht_pkg::*;
(
  input  wire logic        clk_i,
  input  wire store_req_t  req_i,
  output logic [63:0]      rkey_o,
  output logic [63:0]      rval_o
);

  logic [63:0] key_mem [SLOT_COUNT];
  logic [63:0] val_mem [SLOT_COUNT];
  logic [63:0] rkey_q;
  logic [63:0] rval_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.key_we) begin
        key_mem[req_i.addr] <= req_i.wkey;
      end
      rkey_q <= key_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.val_we) begin
        val_mem[req_i.addr] <= req_i.wval;
      end
      rval_q <= val_mem[req_i.addr];
    end
  end

  assign rkey_o = rkey_q;
  assign rval_o = rval_q;

endmodule
`default_nettype wire

### rtl/linear_probe_hash_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table of 64-bit keys and values with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   A request (cmd, key, value) is taken on req_valid_i/req_ready_o; each
//   request gives exactly one response (status, found_value, occupancy) on
//   rsp_valid_o/rsp_ready_i. Insert stores a new key, ignores a present key
//   and is refused once the table holds more than 90 percent of its slots.
//   Lookup returns the stored value or not found. Key zero acts as key one.
// Timing:
//   One request at a time. A request passes through the home slot mix on
//   the shared 32x32 multiplier (two 64-bit multiplies), then probes one
//   slot at a time, limited by the single port of the slot store. An insert
//   refused by the load check skips mix and probe.
// Reset:
//   After reset the key store is swept to empty, one slot per cycle, over all
//   2^TABLE_BITS slots (65536 at the default) with req_ready_o low.
// Stall:
//   The response sits in an output register; a new request is accepted while
//   it waits, and the next response holds in place until that register frees.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core
  import lpht_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire lpht_req_t req_i,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  output lpht_rsp_t      rsp_o
);

  core_state_e           state_q, state_d;
  logic [TABLE_BITS-1:0] clr_q, clr_d;
  logic [TABLE_BITS-1:0] pos_q, pos_d;
  logic [TABLE_BITS-1:0] probe_q, probe_d;
  logic [CNT_W-1:0]      count_q, count_d;
  cmd_e                  cmd_q, cmd_d;
  logic [63:0]           key_q, key_d;
  logic [63:0]           val_q, val_d;
  status_e               status_q, status_d;
  logic [63:0]           fval_q, fval_d;
  logic                  out_valid_q, out_valid_d;
  lpht_rsp_t             out_q, out_d;
  logic                  out_load;
  logic [63:0]           in_key;
  logic                  hash_start;
  logic                  hash_done;
  logic [TABLE_BITS-1:0] hash_slot;
  store_req_t            store_req;
  logic [63:0]           rkey;
  logic [63:0]           rval;
  logic                  is_insert;

  lpht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (in_key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  lpht_store u_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .rkey_o (rkey),
    .rval_o (rval)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    probe_q  <= probe_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    val_q    <= val_d;
    status_q <= status_d;
    fval_q   <= fval_d;
    out_q    <= out_d;
  end

  // zero marks an empty slot, so key zero is stored as one
  assign in_key    = (req_i.key == 64'd0) ? 64'd1 : req_i.key;
  assign is_insert = (cmd_q == CMD_INSERT);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    probe_d     = probe_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    status_d    = status_q;
    fval_d      = fval_q;
    store_req   = '0;
    hash_start  = 1'b0;
    req_ready_o = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      CS_CLEAR: begin
        store_req.en     = 1'b1;
        store_req.key_we = 1'b1;
        store_req.addr   = clr_q;
        clr_d            = clr_q + 1'b1;
        if (clr_q == SLOT_MASK) begin
          state_d = CS_IDLE;
        end
      end
      CS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d  = req_i.cmd;
          key_d  = in_key;
          val_d  = req_i.value;
          fval_d = 64'd0;
          // load check comes before any probe
          if (req_i.cmd == CMD_INSERT && count_q > LOAD_LIMIT) begin
            status_d = ST_REJECTED;
            state_d  = CS_RESP;
          end else begin
            hash_start = 1'b1;
            state_d    = CS_HASH;
          end
        end
      end
      CS_HASH: begin
        if (hash_done) begin
          store_req.en   = 1'b1;
          store_req.addr = hash_slot;
          pos_d          = hash_slot;
          probe_d        = '0;
          state_d        = CS_PROBE;
        end
      end
      CS_PROBE: begin
        priority if (rkey == 64'd0) begin
          if (is_insert) begin
            store_req.en     = 1'b1;
            store_req.key_we = 1'b1;
            store_req.val_we = 1'b1;
            store_req.addr   = pos_q;
            store_req.wkey   = key_q;
            store_req.wval   = val_q;
            count_d          = count_q + 1'b1;
            status_d         = ST_INSERTED;
          end else begin
            status_d = ST_NOT_FOUND;
          end
          state_d = CS_RESP;
        end else if (rkey == key_q) begin
          if (is_insert) begin
            status_d = ST_DUPLICATE;
          end else begin
            status_d = ST_FOUND;
            fval_d   = rval;
          end
          state_d = CS_RESP;
        end else if (probe_q == SLOT_MASK) begin
          // whole table walked without a match or a hole
          status_d = is_insert ? ST_REJECTED : ST_NOT_FOUND;
          state_d  = CS_RESP;
        end else begin
          store_req.en   = 1'b1;
          store_req.addr = pos_q + 1'b1;
          pos_d          = pos_q + 1'b1;
          probe_d        = probe_q + 1'b1;
        end
      end
      CS_RESP: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_load = 1'b1;
          state_d  = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d       = 1'b1;
      out_d.status      = status_q;
      out_d.found_value = fval_q;
      out_d.occupancy   = 17'(count_q);
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule
`default_nettype wire

### rtl/lpht_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks for the hash table core, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  input  wire logic      req_ready_i,
  input  wire logic      rsp_valid_i,
  input  wire logic      rsp_ready_i,
  input  wire lpht_rsp_t rsp_i
);

  // a waiting response holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("response changed while stalled");

  // the core is not ready again in the cycle after it takes a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted back to back");

  // only a hit carries a value
  a_value_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.status != ST_FOUND |-> rsp_i.found_value == 64'd0)
    else $error("nonzero value without a hit");

  // a fresh insert leaves at least one entry
  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.status == ST_INSERTED |-> rsp_i.occupancy != 17'd0)
    else $error("insert reported with empty table");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_i (req_ready_o),
  .rsp_valid_i (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_i       (rsp_o)
);
`default_nettype wire

### tb/linear_probe_hash_table_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core_tb
// Self-checking bench for the linear probing hash table: a directed table of
// corner requests, a random mix of inserts and lookups, part of whose keys
// crowd into one region near the top of the slot range, and finally a burst
// with no idling on either side. Responses are checked against a shadow copy
// of the slot store in the bench, or against a directed row's fixed response.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core_tb;
  import lpht_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 30;
  localparam int POOL_MAX         = 256;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PAT_5    = 64'h5555_5555_5555_5555;
  localparam logic [63:0] PAT_A    = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct {
    lpht_req_t req;
    bit        fixed;
    lpht_rsp_t rsp;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      drv_valid;
  lpht_req_t drv_req;
  bit        drv_fixed;
  lpht_rsp_t drv_fixed_rsp;
  logic      req_ready;
  logic      rsp_valid;
  logic      rsp_ready;
  lpht_rsp_t rsp_data;

  bit        send_idle_on = 1'b1;
  bit        recv_idle_on = 1'b1;
  bit        hold_long    = 1'b0;

  // shadow of the slot store
  bit [63:0] shadow_keys [SLOT_COUNT];
  bit [63:0] shadow_vals [SLOT_COUNT];
  int        shadow_cnt = 0;

  lpht_rsp_t awaited_rsp_q [$];
  logic [63:0] known_keys [$];
  dir_row_t  dir_rows [$];

  lpht_rsp_t calc_rsp;
  lpht_rsp_t want_rsp;
  int        err_cnt = 0;
  int        req_cnt = 0;
  int        rsp_cnt = 0;
  int        peak_occ = 0;
  int        status_seen [5] = '{default: 0};
  int        cycle_cnt = 0;

  linear_probe_hash_table_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(drv_valid),
    .req_ready_o(req_ready),
    .req_i      (drv_req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : reset_gen
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still owed", cycle_cnt,
               awaited_rsp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // home slot: xor-shift / multiply finalizer, low bits select the slot
  function automatic logic [TABLE_BITS-1:0] home_slot(input logic [63:0] k);
    logic [63:0] x;
    x = k ^ (k >> 33);
    x = x * 64'hff51afd7ed558ccd;
    x = x ^ (x >> 33);
    x = x * 64'hc4ceb9fe1a85ec53;
    x = x ^ (x >> 33);
    return x[TABLE_BITS-1:0];
  endfunction

  function automatic lpht_rsp_t table_op_result(input lpht_req_t r);
    lpht_rsp_t             o;
    logic [63:0]           k;
    logic [TABLE_BITS-1:0] pos;
    bit                    hit;
    bit                    hole;
    int                    n;
    k = (r.key == 64'd0) ? 64'd1 : r.key;
    o.found_value = '0;
    o.status = ST_NOT_FOUND;
    hit = 1'b0;
    hole = 1'b0;
    // load check comes before any probing
    if (r.cmd == CMD_INSERT && shadow_cnt * 10 > SLOT_COUNT * 9) begin
      o.status = ST_REJECTED;
    end else begin
      pos = home_slot(k);
      for (n = 0; n < SLOT_COUNT && !hit && !hole; n++) begin
        if (shadow_keys[pos] == 64'd0) begin
          hole = 1'b1;
        end else if (shadow_keys[pos] == k) begin
          hit = 1'b1;
        end else begin
          pos = pos + 1'b1;
        end
      end
      if (r.cmd == CMD_LOOKUP) begin
        if (hit) begin
          o.status = ST_FOUND;
          o.found_value = shadow_vals[pos];
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end else if (hit) begin
        o.status = ST_DUPLICATE;
      end else if (!hole) begin
        o.status = ST_REJECTED;
      end else begin
        shadow_keys[pos] = k;
        shadow_vals[pos] = r.value;
        shadow_cnt++;
        o.status = ST_INSERTED;
      end
    end
    o.occupancy = 17'(shadow_cnt);
    return o;
  endfunction

  function automatic logic [63:0] key_at_slot(input logic [TABLE_BITS-1:0] slot);
    logic [63:0] k;
    k = {$urandom, $urandom} | 64'd2;
    while (home_slot(k) != slot) k = k + 64'd1;
    return k;
  endfunction

  // keys whose home lands in the top 16 slots, so clusters form and wrap
  function automatic logic [63:0] crowded_key();
    logic [63:0] k;
    k = {$urandom, $urandom} | 64'd2;
    while (home_slot(k) < SLOT_COUNT - 16) k = k + 64'd1;
    return k;
  endfunction

  function automatic dir_row_t mk_row(input cmd_e c, input logic [63:0] k,
                                      input logic [63:0] v, input bit fixed,
                                      input status_e st, input logic [63:0] fv,
                                      input int occ);
    dir_row_t d;
    d.req.cmd = c;
    d.req.key = k;
    d.req.value = v;
    d.fixed = fixed;
    d.rsp.status = st;
    d.rsp.found_value = fv;
    d.rsp.occupancy = 17'(occ);
    return d;
  endfunction

  function automatic lpht_req_t random_request();
    lpht_req_t r;
    int        pick;
    r.value = {$urandom, $urandom};
    r.cmd = ($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_LOOKUP;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: r.key = 64'd0;
        1: r.key = 64'd1;
        2: r.key = ALL_ONES;
        default: r.key = TOP_BIT;
      endcase
    end else if (pick < 40 && known_keys.size() != 0) begin
      r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end else if (pick < 60) begin
      r.key = crowded_key();
    end else begin
      r.key = {$urandom, $urandom};
    end
    if (r.cmd == CMD_INSERT && known_keys.size() < POOL_MAX) known_keys.push_back(r.key);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", what);
  endtask

  task automatic offer(input lpht_req_t r, input bit fixed, input lpht_rsp_t frsp);
    int gap;
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      drv_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv_valid <= 1'b1;
    drv_req <= r;
    drv_fixed <= fixed;
    drv_fixed_rsp <= frsp;
    @(posedge clk);
    while (req_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic offer_checked(input lpht_req_t r);
    offer(r, 1'b0, '0);
  endtask

  // sender stops and waits for every owed response
  task automatic drain();
    drv_valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp_q.size() != 0) @(posedge clk);
  endtask

  initial begin : rsp_side
    int gap;
    forever begin
      if (hold_long) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (drv_valid === 1'b1 && req_ready === 1'b1) begin
      calc_rsp = table_op_result(drv_req);
      if (drv_fixed) calc_rsp = drv_fixed_rsp;
      awaited_rsp_q.push_back(calc_rsp);
      req_cnt++;
      status_seen[int'(calc_rsp.status)]++;
      if (int'(calc_rsp.occupancy) > peak_occ) peak_occ = int'(calc_rsp.occupancy);
    end
    if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
      rsp_cnt++;
      if (awaited_rsp_q.size() == 0) begin
        flag_mismatch("response with no request outstanding");
      end else begin
        want_rsp = awaited_rsp_q.pop_front();
        if (rsp_data.status !== want_rsp.status)
          flag_mismatch($sformatf("response %0d status exp %0d got %0d", rsp_cnt,
                                  want_rsp.status, rsp_data.status));
        if (rsp_data.found_value !== want_rsp.found_value)
          flag_mismatch($sformatf("response %0d found_value exp %h got %h", rsp_cnt,
                                  want_rsp.found_value, rsp_data.found_value));
        if (rsp_data.occupancy !== want_rsp.occupancy)
          flag_mismatch($sformatf("response %0d occupancy exp %0d got %0d", rsp_cnt,
                                  want_rsp.occupancy, rsp_data.occupancy));
      end
    end
  end

  initial begin : stimulus
    logic [63:0] wrap_keys [4];
    lpht_req_t   r;
    int          i;

    drv_valid <= 1'b0;
    drv_req <= '0;
    drv_fixed <= 1'b0;
    drv_fixed_rsp <= '0;

    for (i = 0; i < 4; i++) wrap_keys[i] = key_at_slot(SLOT_MASK);

    // key zero is the same as key one; value is ignored on lookup
    dir_rows.push_back(mk_row(CMD_LOOKUP, 64'd0, ALL_ONES, 1'b1, ST_NOT_FOUND, 64'd0, 0));
    dir_rows.push_back(mk_row(CMD_LOOKUP, 64'd1, 64'd0, 1'b1, ST_NOT_FOUND, 64'd0, 0));
    dir_rows.push_back(mk_row(CMD_INSERT, 64'd0, ALL_ONES, 1'b1, ST_INSERTED, 64'd0, 1));
    dir_rows.push_back(mk_row(CMD_LOOKUP, 64'd1, 64'd0, 1'b1, ST_FOUND, ALL_ONES, 1));
    dir_rows.push_back(mk_row(CMD_LOOKUP, 64'd0, 64'd0, 1'b1, ST_FOUND, ALL_ONES, 1));
    dir_rows.push_back(mk_row(CMD_INSERT, 64'd1, 64'd5, 1'b1, ST_DUPLICATE, 64'd0, 1));
    dir_rows.push_back(mk_row(CMD_INSERT, ALL_ONES, 64'd0, 1'b1, ST_INSERTED, 64'd0, 2));
    dir_rows.push_back(mk_row(CMD_LOOKUP, ALL_ONES, 64'd0, 1'b1, ST_FOUND, 64'd0, 2));
    dir_rows.push_back(mk_row(CMD_INSERT, TOP_BIT, PAT_5, 1'b1, ST_INSERTED, 64'd0, 3));
    dir_rows.push_back(mk_row(CMD_INSERT, 64'd2, PAT_A, 1'b1, ST_INSERTED, 64'd0, 4));
    dir_rows.push_back(mk_row(CMD_LOOKUP, TOP_BIT, 64'd0, 1'b1, ST_FOUND, PAT_5, 4));
    dir_rows.push_back(mk_row(CMD_LOOKUP, 64'd2, 64'd0, 1'b1, ST_FOUND, PAT_A, 4));
    dir_rows.push_back(mk_row(CMD_LOOKUP, 64'd3, 64'd0, 1'b1, ST_NOT_FOUND, 64'd0, 4));
    dir_rows.push_back(mk_row(CMD_INSERT, 64'd2, 64'd0, 1'b1, ST_DUPLICATE, 64'd0, 4));
    dir_rows.push_back(mk_row(CMD_LOOKUP, PAT_A, ALL_ONES, 1'b1, ST_NOT_FOUND, 64'd0, 4));
    // same home slot at the very top: the probe wraps to slot zero
    for (i = 0; i < 3; i++)
      dir_rows.push_back(mk_row(CMD_INSERT, wrap_keys[i], {$urandom, $urandom}, 1'b0,
                                ST_INSERTED, 64'd0, 0));
    dir_rows.push_back(mk_row(CMD_LOOKUP, wrap_keys[2], 64'd0, 1'b0, ST_FOUND, 64'd0, 0));
    dir_rows.push_back(mk_row(CMD_LOOKUP, wrap_keys[3], 64'd0, 1'b0, ST_FOUND, 64'd0, 0));
    dir_rows.push_back(mk_row(CMD_INSERT, wrap_keys[3], PAT_5, 1'b0, ST_INSERTED, 64'd0, 0));
    dir_rows.push_back(mk_row(CMD_LOOKUP, wrap_keys[3], 64'd0, 1'b0, ST_FOUND, 64'd0, 0));

    wait (rst_n === 1'b1);
    @(posedge clk);

    foreach (dir_rows[n]) offer(dir_rows[n].req, dir_rows[n].fixed, dir_rows[n].rsp);

    for (i = 0; i < 170; i++) offer_checked(random_request());

    drain();

    // receiver holds off while requests keep coming, so the block backs up
    send_idle_on = 1'b0;
    hold_long = 1'b1;
    for (i = 0; i < 24; i++) offer_checked(random_request());
    send_idle_on = 1'b1;

    for (i = 0; i < 170; i++) offer_checked(random_request());

    // last part: no idling on either side
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    drain();
    for (i = 0; i < 12; i++) offer_checked(random_request());
    r.cmd = CMD_LOOKUP;
    r.value = 64'd0;
    for (i = 0; i < 4; i++) begin
      r.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      offer_checked(r);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d responses checked, peak occupancy %0d", req_cnt, rsp_cnt,
             peak_occ);
    $display("inserted %0d, duplicate %0d, refused %0d, found %0d, missing %0d",
             status_seen[ST_INSERTED], status_seen[ST_DUPLICATE], status_seen[ST_REJECTED],
             status_seen[ST_FOUND], status_seen[ST_NOT_FOUND]);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

### linear_probe_hash_table_core.f
rtl/lpht_pkg.sv
rtl/lpht_hash.sv
rtl/lpht_store.sv
rtl/linear_probe_hash_table_core.sv
rtl/lpht_checker.sv
tb/linear_probe_hash_table_core_tb.sv
